### src/utli_pkg.sv
// shared constants, status codes and controller/datapath interface types
package utli_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int CFG_W      = 7;
  localparam int DATA_W     = 32;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);
  localparam int STATUS_W   = 3;

  localparam logic [STATUS_W-1:0] ST_INTERP = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXACT  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BELOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABOVE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic load_we;
    logic q_load;
    logic scan_clr;
    logic rd_en;
    logic prep;
    logic mul;
    logic div_init;
    logic div_step;
    logic res_load;
  } utli_cmd_t;

  typedef struct packed {
    logic interp;
  } utli_sts_t;

endpackage

### src/utli_ctrl.sv
// controller: request handshake, point count register and sequencing fsm
module utli_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    op,
  output logic                    busy,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [utli_pkg::CFG_W-1:0] cfg_point_count,
  output logic                    out_valid,
  output utli_pkg::utli_cmd_t     cmd,
  input  utli_pkg::utli_sts_t     sts,
  output logic [utli_pkg::IDX_W-1:0] rd_addr
);
  import utli_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DINIT = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_RES   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [CFG_W-1:0]  count_cfg_r;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic [CNT_W-1:0]  n_clamped;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;
  assign out_valid = out_valid_r;
  assign rd_addr   = cnt_r[IDX_W-1:0];

  // counts above the table depth scan the whole table
  assign n_clamped = (count_cfg_r > CFG_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(count_cfg_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    dcnt_nxt      = dcnt_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && op == OP_LOAD) begin
          cmd.load_we = 1'b1;
        end else if (accept) begin
          cmd.q_load   = 1'b1;
          cmd.scan_clr = 1'b1;
          cnt_nxt      = '0;
          n_nxt        = n_clamped;
          state_nxt    = (n_clamped == '0) ? S_RES : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == n_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.prep  = 1'b1;
        state_nxt = sts.interp ? S_MUL : S_RES;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        cmd.res_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      dcnt_r      <= '0;
      count_cfg_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        count_cfg_r <= cfg_point_count;
      end
    end
  end

endmodule

### src/utli_dp.sv
// datapath: point memories, bracket search, multiplier and serial divider
module utli_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  utli_pkg::utli_cmd_t           cmd,
  output utli_pkg::utli_sts_t           sts,
  input  logic [utli_pkg::IDX_W-1:0]    rd_addr,
  input  logic [utli_pkg::IDX_W-1:0]    wr_addr,
  input  logic signed [utli_pkg::DATA_W-1:0] wr_x,
  input  logic signed [utli_pkg::DATA_W-1:0] wr_y,
  input  logic signed [utli_pkg::DATA_W-1:0] query_x,
  output logic signed [utli_pkg::DATA_W-1:0] y_result,
  output logic [utli_pkg::STATUS_W-1:0] status
);
  import utli_pkg::*;

  logic [DATA_W-1:0] mem_x [MAX_POINTS];
  logic [DATA_W-1:0] mem_y [MAX_POINTS];

  logic [DATA_W-1:0]   rdx_r, rdy_r;
  logic                rd_vld_r;
  logic [DATA_W-1:0]   q_r;
  logic                have_lo_r, have_hi_r;
  logic [DATA_W-1:0]   lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic [DATA_W-1:0]   a_r, b_r, d_r;
  logic                neg_r;
  logic [2*DATA_W-1:0] prod_r;
  logic [DATA_W-1:0]   rem_r, quo_r;
  logic [DATA_W-1:0]   y_res_r;
  logic [STATUS_W-1:0] status_r;

  logic              le_q, ge_q, take_lo, take_hi;
  logic              interp;
  logic [DATA_W:0]   dy, trial;
  logic [DATA_W:0]   dy_mag;
  logic              fits;

  // memories: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem_x[wr_addr] <= wr_x;
      mem_y[wr_addr] <= wr_y;
    end
    if (cmd.rd_en) begin
      rdx_r <= mem_x[rd_addr];
      rdy_r <= mem_y[rd_addr];
    end
  end

  // bracket search, ties keep the earliest entry
  assign le_q    = $signed(rdx_r) <= $signed(q_r);
  assign ge_q    = $signed(rdx_r) >= $signed(q_r);
  assign take_lo = rd_vld_r && le_q && (!have_lo_r || $signed(rdx_r) > $signed(lo_x_r));
  assign take_hi = rd_vld_r && ge_q && (!have_hi_r || $signed(rdx_r) < $signed(hi_x_r));

  assign interp     = have_lo_r && have_hi_r && (lo_x_r != hi_x_r);
  assign sts.interp = interp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      have_lo_r <= 1'b0;
      have_hi_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.scan_clr) begin
        have_lo_r <= 1'b0;
        have_hi_r <= 1'b0;
      end else begin
        if (take_lo) have_lo_r <= 1'b1;
        if (take_hi) have_hi_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_r <= query_x;
    end
    if (take_lo) begin
      lo_x_r <= rdx_r;
      lo_y_r <= rdy_r;
    end
    if (take_hi) begin
      hi_x_r <= rdx_r;
      hi_y_r <= rdy_r;
    end
  end

  // operand set-up: both differences are below 2^32 as the query lies strictly inside
  assign dy     = {hi_y_r[DATA_W-1], hi_y_r} - {lo_y_r[DATA_W-1], lo_y_r};
  assign dy_mag = dy[DATA_W] ? (~dy + 1'b1) : dy;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      a_r   <= q_r - lo_x_r;
      d_r   <= hi_x_r - lo_x_r;
      b_r   <= dy_mag[DATA_W-1:0];
      neg_r <= dy[DATA_W];
    end
    if (cmd.mul) begin
      prod_r <= (2*DATA_W)'(a_r) * (2*DATA_W)'(b_r);
    end
  end

  // restoring divider, one quotient bit a step; upper half is below the divisor
  assign trial = {rem_r, quo_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= prod_r[2*DATA_W-1:DATA_W];
      quo_r <= prod_r[DATA_W-1:0];
    end else if (cmd.div_step) begin
      rem_r <= fits ? DATA_W'(trial - {1'b0, d_r}) : trial[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], fits};
    end
  end

  // result select
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (interp) begin
        y_res_r  <= neg_r ? (lo_y_r - quo_r) : (lo_y_r + quo_r);
        status_r <= ST_INTERP;
      end else if (have_lo_r && have_hi_r) begin
        y_res_r  <= lo_y_r;
        status_r <= ST_EXACT;
      end else if (have_hi_r) begin
        y_res_r  <= hi_y_r;
        status_r <= ST_BELOW;
      end else if (have_lo_r) begin
        y_res_r  <= lo_y_r;
        status_r <= ST_ABOVE;
      end else begin
        y_res_r  <= '0;
        status_r <= ST_EMPTY;
      end
    end
  end

  assign y_result = y_res_r;
  assign status   = status_r;

endmodule

### src/unsorted_table_linear_interpolator.sv
// top level: piecewise linear interpolator over an unsorted point table
// a load request completes without the block going busy; a query scans n entries
//   (n = min(point_count, 64)), then when interpolating prepares, multiplies and runs a
//   32-step serial divide; an exact hit or clamp skips both, an empty table skips to the result
// next request is taken in the strobe cycle; scan length plus the serial divide set throughput
// result is strobed on out_valid for one cycle only; the receiver cannot stall
// synchronous active-low reset clears the fsm, the strobe and point_count; point memory keeps data
module unsorted_table_linear_interpolator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [utli_pkg::IDX_W-1:0]           in_point_index,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_point_x,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_point_y,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_query_x,
  // result channel
  output logic                                 out_valid,
  output logic signed [utli_pkg::DATA_W-1:0]   out_y_result,
  output logic [utli_pkg::STATUS_W-1:0]        out_status,
  // configuration
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [utli_pkg::CFG_W-1:0]           cfg_point_count
);
  import utli_pkg::*;

  utli_cmd_t        cmd;
  utli_sts_t        sts;
  logic [IDX_W-1:0] rd_addr;

  // sequencing: handshake, scan addressing, divider step count
  utli_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .op              (in_op),
    .busy            (busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_point_count (cfg_point_count),
    .out_valid       (out_valid),
    .cmd             (cmd),
    .sts             (sts),
    .rd_addr         (rd_addr)
  );

  // storage and arithmetic
  utli_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .rd_addr  (rd_addr),
    .wr_addr  (in_point_index),
    .wr_x     (in_point_x),
    .wr_y     (in_point_y),
    .query_x  (in_query_x),
    .y_result (out_y_result),
    .status   (out_status)
  );

  // a result strobe is never held; out_valid always drops again straight away
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // an accepted query always makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // a load completes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_LOAD) |=> (!busy && !out_valid))
    else $error("load request caused busy or a result");

  // an empty table answers zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_y_result == '0))
    else $error("empty-table result not zero");

endmodule

### tb/sv/utli_interp_checker.sv
// checker for the interpolator: tracks the point table, predicts each answer and compares
module utli_interp_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic                                 in_op,
  input  logic [utli_pkg::IDX_W-1:0]           in_point_index,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_point_x,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_point_y,
  input  logic signed [utli_pkg::DATA_W-1:0]   in_query_x,
  input  logic                                 out_valid,
  input  logic signed [utli_pkg::DATA_W-1:0]   out_y_result,
  input  logic [utli_pkg::STATUS_W-1:0]        out_status,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [utli_pkg::CFG_W-1:0]           cfg_point_count,
  output int                                   fail_count,
  output int                                   pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import utli_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic [STATUS_W-1:0]      st;
  } answer_t;

  logic signed [DATA_W-1:0] pts_x [MAX_POINTS];
  logic signed [DATA_W-1:0] pts_y [MAX_POINTS];
  logic [CFG_W-1:0]         scan_count;
  answer_t                  answer_q [$];
  answer_t                  want;
  int                       mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    scan_count = '0;
  end

  // bracket search over the scanned entries, then multiply before divide
  function automatic answer_t interpolate(logic signed [DATA_W-1:0] q);
    answer_t    r;
    int         n;
    int         lo;
    int         hi;
    bit         got_lo;
    bit         got_hi;
    longint     ylo;
    longint     dy;
    longint     yv;
    bit [63:0]  run;
    bit [63:0]  span;
    bit [63:0]  rise;
    bit [63:0]  quot;
    n = (scan_count > MAX_POINTS) ? MAX_POINTS : int'(scan_count);
    if (n == 0) begin
      r.y  = '0;
      r.st = ST_EMPTY;
      return r;
    end
    lo = 0;
    hi = 0;
    got_lo = 1'b0;
    got_hi = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (pts_x[i] <= q && (!got_lo || pts_x[i] > pts_x[lo])) begin
        lo = i;
        got_lo = 1'b1;
      end
      if (pts_x[i] >= q && (!got_hi || pts_x[i] < pts_x[hi])) begin
        hi = i;
        got_hi = 1'b1;
      end
    end
    if (got_lo && got_hi && lo != hi) begin
      ylo  = longint'(pts_y[lo]);
      run  = longint'(q) - longint'(pts_x[lo]);
      span = longint'(pts_x[hi]) - longint'(pts_x[lo]);
      dy   = longint'(pts_y[hi]) - ylo;
      rise = (dy < 0) ? -dy : dy;
      // both factors below 2**32, so the product is exact in 64 bits
      quot = (run * rise) / span;
      yv   = (dy < 0) ? ylo - longint'(quot) : ylo + longint'(quot);
      r.y  = yv[DATA_W-1:0];
      r.st = ST_INTERP;
    end else if (got_lo && got_hi) begin
      r.y  = pts_y[lo];
      r.st = ST_EXACT;
    end else if (!got_lo) begin
      r.y  = pts_y[hi];
      r.st = ST_BELOW;
    end else begin
      r.y  = pts_y[lo];
      r.st = ST_ABOVE;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      scan_count = '0;
      answer_q.delete();
    end else begin
      // result first: it always belongs to an earlier request
      if (out_valid) begin
        if (answer_q.size() == 0) begin
          $error("result with nothing outstanding: y_result %0d, status %0d",
                 out_y_result, out_status);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          if (out_y_result !== want.y) begin
            $error("y_result: expected %0d, actual %0d", want.y, out_y_result);
            mismatches++;
          end
          if (out_status !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, out_status);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        scan_count = cfg_point_count;
      if (start && !busy) begin
        if (in_op == OP_LOAD) begin
          pts_x[in_point_index] = in_point_x;
          pts_y[in_point_index] = in_point_y;
        end else begin
          answer_q.push_back(interpolate(in_query_x));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= answer_q.size();
  end

endmodule

### tb/sv/tb_unsorted_table_linear_interpolator.sv
// testbench top: drives loads, queries and point_count settings, gives the verdict
module tb_unsorted_table_linear_interpolator;

  timeunit 1ns;
  timeprecision 1ps;

  import utli_pkg::*;

  localparam int PERIOD       = 10;
  localparam int WATCHDOG_MAX = 5000;
  localparam int DRAIN_CYCLES = 110;   // outlasts the slowest query, a full 64-entry scan plus divide
  localparam int PHASES       = 15;
  localparam int PHASE_ITEMS  = 22;

  localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_op = OP_LOAD;
  logic [IDX_W-1:0]          in_point_index = '0;
  logic signed [DATA_W-1:0]  in_point_x = '0;
  logic signed [DATA_W-1:0]  in_point_y = '0;
  logic signed [DATA_W-1:0]  in_query_x = '0;
  logic                      out_valid;
  logic signed [DATA_W-1:0]  out_y_result;
  logic [STATUS_W-1:0]       out_status;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_point_count = '0;

  int fail_count;
  int pending;
  int idle_cycles = 0;

  // stimulus-side view of the table, only used to aim queries and avoid unwritten entries
  logic signed [DATA_W-1:0] sh_x [MAX_POINTS];
  bit                       written [MAX_POINTS];
  int                       cur_count = 0;
  int                       idle_pct = 27;

  // mostly small counts, a few at and beyond the table size
  int count_plan [PHASES] = '{3, 1, 64, 5, 2, 16, 127, 7, 0, 4, 100, 6, 8, 2, 65};

  always #(PERIOD / 2) clk = ~clk;

  unsorted_table_linear_interpolator dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_point_index  (in_point_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_query_x      (in_query_x),
    .out_valid       (out_valid),
    .out_y_result    (out_y_result),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_point_count (cfg_point_count)
  );

  utli_interp_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_point_index  (in_point_index),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_query_x      (in_query_x),
    .out_valid       (out_valid),
    .out_y_result    (out_y_result),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_point_count (cfg_point_count),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // watchdog: any request, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // entries that a query scans with the current setting
  function automatic int scanned();
    return (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
  endfunction

  // coordinates: extremes, a few small values that collide often, or anything
  function automatic logic signed [DATA_W-1:0] rand_coord();
    int step;
    step = int'($urandom_range(0, 6)) - 3;
    case ($urandom_range(0, 9))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2, 3, 4: return step * Q_ONE;
      default: return $urandom;
    endcase
  endfunction

  // queries aimed at table points, their neighbours and the gaps between them, or extremes, or random
  function automatic logic signed [DATA_W-1:0] pick_query();
    int     n;
    int     i;
    int     j;
    longint mid;
    n = scanned();
    if (n == 0)
      return rand_coord();
    i = $urandom_range(0, n - 1);
    j = $urandom_range(0, n - 1);
    mid = (longint'(sh_x[i]) + longint'(sh_x[j])) / 2;
    case ($urandom_range(0, 7))
      0:       return sh_x[i];
      1:       return sh_x[i] + 1;
      2:       return sh_x[i] - 1;
      3:       return mid[DATA_W-1:0];
      4:       return Q_MIN;
      5:       return Q_MAX;
      default: return $urandom;
    endcase
  endfunction

  // present one request from the falling edge and hold it until it is taken
  task automatic drive_req(input logic op, input logic [IDX_W-1:0] idx,
                           input logic signed [DATA_W-1:0] px,
                           input logic signed [DATA_W-1:0] py,
                           input logic signed [DATA_W-1:0] qx);
    @(negedge clk);
    start          <= 1'b1;
    in_op          <= op;
    in_point_index <= idx;
    in_point_x     <= px;
    in_point_y     <= py;
    in_query_x     <= qx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // unused fields carry junk so that every bit toggles
  task automatic send_load(input int idx, input logic signed [DATA_W-1:0] px,
                           input logic signed [DATA_W-1:0] py);
    written[idx] = 1'b1;
    sh_x[idx]    = px;
    drive_req(OP_LOAD, idx[IDX_W-1:0], px, py, $urandom);
  endtask

  task automatic send_query(input logic signed [DATA_W-1:0] qx);
    drive_req(OP_QUERY, IDX_W'($urandom), $urandom, $urandom, qx);
  endtask

  // drop start at the edge after the last request so it is not taken twice
  task automatic hold_requests();
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_results();
    hold_requests();
    while (pending != 0) @(negedge clk);
  endtask

  // register write only with the block idle
  task automatic set_count(input int n);
    drain_results();
    while (busy) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_valid       <= 1'b1;
    cfg_point_count <= n[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_count = n;
  endtask

  initial begin
    int n;
    for (int i = 0; i < MAX_POINTS; i++) begin
      written[i] = 1'b0;
      sh_x[i]    = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    // empty table straight after reset, extremes of the query
    send_query(Q_MIN);
    send_query(Q_MAX);
    // full-range span, two points sharing x = 0, and the top entry
    send_load(0, Q_MIN, Q_MAX);
    send_load(1, Q_MAX, Q_MIN);
    send_load(2, '0, 32'sh1234_5678);
    send_load(3, '0, -32'sd5);
    send_load(MAX_POINTS - 1, -32'sd1, Q_MAX);

    set_count(2);
    // widest possible bracket with falling y, and exact hits on both ends
    send_query('0);
    send_query(Q_MIN);
    send_query(Q_MAX);
    send_query(Q_MIN + 1);
    send_query(-32'sd1);

    set_count(4);
    // exact hit on a repeated x must take the earlier entry
    send_query('0);
    send_query(32'sd1);
    // pull the ends inwards so both clamps can happen
    send_load(0, -Q_ONE, Q_MIN);
    send_load(1, Q_ONE, Q_MAX);
    send_query(Q_MIN);
    send_query(Q_MAX);
    send_query(32'sh0000_8000);

    // ---- random part ----
    for (int p = 0; p < PHASES; p++) begin
      // sender idling in three bands: moderate, heavy, none
      idle_pct = (p < PHASES / 3) ? 27 : (p < 2 * PHASES / 3) ? 86 : 0;
      set_count(count_plan[p]);
      n = scanned();
      // every entry the queries will scan must hold a point first
      for (int i = 0; i < n; i++) begin
        if (!written[i]) begin
          sender_gap();
          send_load(i, rand_coord(), rand_coord());
        end
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sender_gap();
        // now and then hold back until every answer is in
        if ($urandom_range(0, 99) < 5)
          drain_results();
        if ($urandom_range(0, 99) < 25) begin
          if (n > 0 && $urandom_range(0, 1) == 1)
            send_load($urandom_range(0, n - 1), rand_coord(), rand_coord());
          else
            send_load($urandom_range(0, MAX_POINTS - 1), rand_coord(), rand_coord());
        end else begin
          send_query(pick_query());
        end
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
src/utli_pkg.sv
src/utli_ctrl.sv
src/utli_dp.sv
src/unsorted_table_linear_interpolator.sv
tb/sv/utli_interp_checker.sv
tb/sv/tb_unsorted_table_linear_interpolator.sv
